// ===== rtl/cms_pkg.sv =====
// Shared constants, types and state encoding for the constant materialization sequencer.
package cms_pkg;

  localparam int VAL_W      = 64;  // constant width
  localparam int REG_W      = 5;   // register number width
  localparam int IMM_W      = 20;  // immediate field width
  localparam int XOR_W      = 12;  // xor-immediate piece width
  localparam int SHAMT_W    = 6;   // shift amount field width
  localparam int MAX_PIECES = 5;
  localparam int SLOT_N     = 2 * MAX_PIECES - 1;  // piece, shift, piece, ...

  localparam logic [1:0] KIND_LUI  = 2'd0;
  localparam logic [1:0] KIND_XORI = 2'd1;
  localparam logic [1:0] KIND_SLLI = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SIZE,
    S_CUT,
    S_EMIT
  } state_t;

  // Run just scanned, handed to the piece sizing unit
  typedef struct packed {
    logic signed [7:0] bitpos;  // first bit past the run, -1 when exhausted
    logic        [6:0] run;     // run length
    logic signed [7:0] start;   // top bit of the run
    logic        [2:0] n;       // pieces cut so far
    logic              upper;   // first piece is an upper load
  } size_req_t;

  // Piece boundaries from the sizing unit
  typedef struct packed {
    logic signed [7:0] bitpos;  // bit just below the piece
    logic        [4:0] width;   // piece width, at most 20
    logic        [6:0] run;     // leftover run folded into the shift
  } size_rsp_t;

endpackage

// ===== rtl/cms_ifs.sv =====
// Valid/ready channel interfaces for constant items and instruction results.
interface cms_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] constant_value;
  logic [4:0]  target_reg;

  modport source (output valid, constant_value, target_reg, input ready);
  modport sink (input valid, constant_value, target_reg, output ready);
endinterface

interface cms_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  insn_kind;
  logic [4:0]  insn_rd;
  logic [4:0]  insn_rs1;
  logic [19:0] insn_imm;
  logic        last_insn;

  modport source (output valid, insn_kind, insn_rd, insn_rs1, insn_imm, last_insn,
                  input ready);
  modport sink (input valid, insn_kind, insn_rd, insn_rs1, insn_imm, last_insn,
                output ready);
endinterface

// ===== rtl/cms_size_unit.sv =====
// Piece sizing unit: turns a scanned run into piece width, position and leftover run.
module cms_size_unit
  import cms_pkg::*;
(
  input  size_req_t req,
  output size_rsp_t rsp
);

  logic signed [7:0] b;
  logic signed [7:0] nb;
  logic        [7:0] w;
  logic        [7:0] r;
  logic        [7:0] s;

  always_comb begin
    b = req.bitpos;
    r = {1'b0, req.run};
    // after an upper load a short run restarts at its top bit
    if (req.n == 3'd1 && req.upper && req.run <= 7'd12) begin
      b = req.start - 8'sd1;
      r = 8'd1;
    end
    w = 8'(b + 8'sd2);
    r = r - 8'd1;
    s = w + r;
    nb = b;

    if (w < 8'd12) begin
      // tail piece: absorb the run up to 12 bits
      if (s > 8'd12) begin
        r = s - 8'd12;
        w = 8'd12;
      end else begin
        w = s;
        r = 8'd0;
      end
      nb = -8'sd1;
    end else if (w > 8'd12) begin
      if (w >= 8'd32 && req.n == 3'd0) begin
        // plain upper load
        nb = 8'(w - 8'd21);
        w  = 8'd20;
      end else if (s >= 8'd32 && req.n == 3'd0) begin
        // upper load that swallows part of the run
        if (s > 8'd32) begin
          r = s - 8'd32;
          w = 8'd20;
        end else begin
          w = s - 8'd12;
          r = 8'd0;
        end
        nb = 8'sd11;
      end else begin
        nb = 8'(w - 8'd13);
        w  = 8'd12;
      end
    end else begin
      nb = b - 8'sd11;
    end

    rsp.bitpos = nb;
    rsp.width  = w[4:0];
    rsp.run    = r[6:0];
  end

endmodule

// ===== rtl/constant_materialize_sequence_core.sv =====
// Top level of the RV64 constant materialization sequencer.
// Takes one 64-bit constant and a destination register per transfer and returns
// the lui/xori/slli sequence that builds it, 1 to 9 instruction results with
// last_insn set on the final one. One item is handled at a time: item.ready is
// high only while idle. For each piece the run scanner starts at the piece
// boundary and examines one bit of the constant per cycle down to the end of
// the run; after the run end the piece is sized and then cut. Bits of a cut
// piece below the bit that ends its run are never scanned, and only the
// rescan after an upper load revisits bits. The emit phase then steps one
// instruction slot per cycle up to the last emitted instruction, stalling
// only while result is not taken. The result register holds the whole
// instruction, destination included, so the next item is taken while the
// last result still waits.
module constant_materialize_sequence_core
  import cms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  cms_in_if.sink    item,
  cms_out_if.source result
);

  state_t state, state_next;

  logic [VAL_W-1:0]   val;
  logic [REG_W-1:0]   dest;
  logic signed [7:0]  bitpos;
  logic signed [7:0]  start;
  logic [6:0]         run;
  logic               top;
  logic [2:0]         n;
  logic               upper;
  logic [4:0]         width;
  logic [3:0]         slot;

  logic [IMM_W-1:0]   piece [MAX_PIECES];
  logic [MAX_PIECES-1:0] inv;
  logic [7:0]         shamt [MAX_PIECES-1];

  logic               out_v;
  logic [1:0]         out_kind;
  logic [REG_W-1:0]   out_rd;
  logic [REG_W-1:0]   out_rs1;
  logic [IMM_W-1:0]   out_imm;
  logic               out_last;

  size_req_t          sz_req;
  size_rsp_t          sz_rsp;

  logic               scan_match;
  logic [5:0]         cut_sh;
  logic [VAL_W-1:0]   shifted;
  logic [IMM_W-1:0]   cut;
  logic [2:0]         n_inc;
  logic [1:0]         n_prev;
  logic [7:0]         sh_sum;
  logic [7:0]         sh_val;
  logic               cut_done;

  logic [SLOT_N-1:0]  mask;
  logic [SLOT_N-1:0]  mask_hi;
  logic               slot_last;
  logic               load_ok;
  logic               emit_now;
  logic [2:0]         pidx;
  logic [1:0]         sidx;
  logic [IMM_W-1:0]   pval;
  logic [1:0]         kind_cur;
  logic [IMM_W-1:0]   imm_cur;

  // Sizing unit
  assign sz_req.bitpos = bitpos;
  assign sz_req.run    = run;
  assign sz_req.start  = start;
  assign sz_req.n      = n;
  assign sz_req.upper  = upper;

  cms_size_unit u_size (
    .req (sz_req),
    .rsp (sz_rsp)
  );

  // Scan and cut datapath
  assign scan_match = !bitpos[7] && (val[bitpos[5:0]] == top);
  assign cut_sh     = 6'(bitpos + 8'sd1);
  assign shifted    = val >> cut_sh;
  assign cut        = shifted[IMM_W-1:0] & ~({IMM_W{1'b1}} << width);
  assign n_inc      = n + 3'd1;
  assign n_prev     = 2'(n - 3'd1);
  assign sh_sum     = {3'b000, width} + {1'b0, run};
  assign sh_val     = (n == 3'd1 && upper) ? sh_sum - 8'd12 : sh_sum;
  assign cut_done   = bitpos[7] || (n_inc >= 3'(MAX_PIECES));

  // Which instruction slots are emitted
  always_comb begin
    for (int i = 0; i < MAX_PIECES; i++) begin
      mask[2*i] = (3'(i) < n) && (i == 0 || inv[i] || piece[i] != '0);
    end
    for (int i = 0; i < MAX_PIECES - 1; i++) begin
      mask[2*i+1] = (3'(i + 1) < n) && (shamt[i] != 8'd0);
    end
  end

  assign mask_hi   = mask >> slot;
  assign slot_last = (mask_hi[SLOT_N-1:1] == '0);
  assign load_ok   = !out_v || result.ready;
  assign emit_now  = (state == S_EMIT) && load_ok && mask[slot];
  assign pidx      = slot[3:1];
  assign sidx      = slot[2:1];
  assign pval      = inv[pidx] ? ~piece[pidx] : piece[pidx];

  // Instruction for the current slot
  always_comb begin
    if (slot[0]) begin
      kind_cur = KIND_SLLI;
      imm_cur  = {{(IMM_W-SHAMT_W){1'b0}}, shamt[sidx][SHAMT_W-1:0]};
    end else if (slot == 4'd0 && upper) begin
      kind_cur = KIND_LUI;
      imm_cur  = pval;
    end else begin
      kind_cur = KIND_XORI;
      imm_cur  = {{(IMM_W-XOR_W){1'b0}}, pval[XOR_W-1:0]};
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (item.valid) state_next = S_START;
      S_START: state_next = S_SCAN;
      S_SCAN:  if (!scan_match) state_next = S_SIZE;
      S_SIZE:  state_next = S_CUT;
      S_CUT:   state_next = cut_done ? S_EMIT : S_START;
      S_EMIT:  if (emit_now && slot_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      n     <= 3'd0;
      upper <= 1'b0;
      slot  <= 4'd0;
      out_v <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          n     <= 3'd0;
          upper <= 1'b0;
        end
        S_CUT: begin
          n <= n_inc;
          if (n == 3'd0 && width == 5'd20) upper <= 1'b1;
          slot <= 4'd0;
        end
        S_EMIT: begin
          if (load_ok) slot <= slot + 4'd1;
        end
        default: begin
        end
      endcase
      if (emit_now) begin
        out_v <= 1'b1;
      end else if (result.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  // Scan and piece registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item.valid) begin
          val    <= item.constant_value;
          dest   <= item.target_reg;
          bitpos <= 8'sd63;
          inv    <= '0;
        end
      end
      S_START: begin
        top    <= val[bitpos[5:0]];
        start  <= bitpos;
        run    <= 7'd1;
        bitpos <= bitpos - 8'sd1;
      end
      S_SCAN: begin
        if (scan_match) begin
          run    <= run + 7'd1;
          bitpos <= bitpos - 8'sd1;
        end
      end
      S_SIZE: begin
        bitpos <= sz_rsp.bitpos;
        width  <= sz_rsp.width;
        run    <= sz_rsp.run;
      end
      S_CUT: begin
        piece[n] <= cut;
        if (n != 3'd0) begin
          shamt[n_prev] <= sh_val;
          if (top && width == 5'd12) inv[n_prev] <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (emit_now) begin
      out_kind <= kind_cur;
      out_rd   <= dest;
      out_rs1  <= (slot == 4'd0) ? '0 : dest;
      out_imm  <= imm_cur;
      out_last <= slot_last;
    end
  end

  assign item.ready       = (state == S_IDLE);
  assign result.valid     = out_v;
  assign result.insn_kind = out_kind;
  assign result.insn_rd   = out_rd;
  assign result.insn_rs1  = out_rs1;
  assign result.insn_imm  = out_imm;
  assign result.last_insn = out_last;

`ifndef SYNTHESIS
  a_piece_bound: assert property (@(posedge clk) disable iff (rst)
    n <= 3'(MAX_PIECES))
    else $error("piece count beyond limit");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> state == S_START)
    else $error("accepted item did not start scan");

  a_first_slot: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && slot == 4'd0 |-> mask[0])
    else $error("first piece not emitted");

  a_lui_rs1: assert property (@(posedge clk) disable iff (rst)
    out_v && out_kind == KIND_LUI |-> out_rs1 == '0)
    else $error("upper load with nonzero source");

  a_shift_imm: assert property (@(posedge clk) disable iff (rst)
    out_v && out_kind == KIND_SLLI |-> out_imm[IMM_W-1:SHAMT_W] == '0)
    else $error("shift amount out of field");
`endif

endmodule
